// File: design/triple_mod_rolling_hash_table_assert.svh
// Assertion macros shared by the RTL; clock and reset names are fixed.
`ifndef TRIPLE_MOD_ROLLING_HASH_TABLE_ASSERT_SVH
`define TRIPLE_MOD_ROLLING_HASH_TABLE_ASSERT_SVH

// Same-cycle implication.
`define TMRH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tmrh assertion failed");

// Next-cycle implication.
`define TMRH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tmrh assertion failed");

`endif

// File: design/tmrh_pkg.sv
// ----------------------------------------------------------------------------
// tmrh_pkg
// Shared types and constants for the triple modulus rolling hash.
// ----------------------------------------------------------------------------
package tmrh_pkg;

  localparam int unsigned RES_W   = 31;
  localparam int unsigned POS_W   = 13;
  localparam int unsigned NUM_MOD = 3;
  localparam int unsigned FOLD_W  = 6;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_LOAD    = 2'd1,
    ACT_QUERY   = 2'd2,
    ACT_COMBINE = 2'd3
  } action_e;

  // Request to the shared multiply-mod unit: (a*b +/- add) mod M[sel]
  typedef struct packed {
    logic             valid;
    logic [RES_W-1:0] a;
    logic [RES_W-1:0] b;
    logic [RES_W-1:0] add;
    logic             sub;
    logic [1:0]       sel;
  } mm_req_t;

  function automatic logic [RES_W-1:0] modulus(input logic [1:0] sel);
    logic [RES_W-1:0] m;
    unique case (sel)
      2'd0:    m = 31'd2147483647;
      2'd1:    m = 31'd2147483629;
      default: m = 31'd2147483587;
    endcase
    return m;
  endfunction

  // 2^31 - M, used to fold the high part back in
  function automatic logic [FOLD_W-1:0] fold(input logic [1:0] sel);
    logic [FOLD_W-1:0] c;
    unique case (sel)
      2'd0:    c = 6'd1;
      2'd1:    c = 6'd19;
      default: c = 6'd61;
    endcase
    return c;
  endfunction

endpackage

// File: design/tmrh_ram.sv
// ----------------------------------------------------------------------------
// tmrh_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tmrh_ram #(
  parameter int unsigned WIDTH = 93,
  parameter int unsigned DEPTH = 4097
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/tmrh_mulmod.sv
// ----------------------------------------------------------------------------
// tmrh_mulmod
// Four-stage (a*b +/- add) mod M unit for pseudo-Mersenne moduli.
// ----------------------------------------------------------------------------
module tmrh_mulmod (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tmrh_pkg::mm_req_t              req_i,
  output logic                           valid_o,
  output logic [tmrh_pkg::RES_W-1:0]     result_o
);

  logic [61:0] prod_q;
  logic [37:0] x_q;
  logic [30:0] r_q, add1_q, add2_q, add3_q;
  logic        sub1_q, sub2_q, sub3_q;
  logic [1:0]  sel1_q, sel2_q, sel3_q;
  logic        v1_q, v2_q, v3_q;

  logic [37:0] x_d;
  logic [31:0] y;
  logic [30:0] m2, m3, r_d, add_d;
  logic [31:0] sum, dif;

  // stage 2: fold high 31 bits once
  assign x_d = 38'(prod_q[61:31]) * 38'(tmrh_pkg::fold(sel1_q)) + 38'(prod_q[30:0]);

  // stage 3: fold again, one subtract, reduce the addend
  assign m2    = tmrh_pkg::modulus(sel2_q);
  assign y     = 32'(x_q[37:31]) * 32'(tmrh_pkg::fold(sel2_q)) + 32'(x_q[30:0]);
  assign r_d   = (y >= {1'b0, m2}) ? 31'(y - {1'b0, m2}) : y[30:0];
  assign add_d = (add2_q >= m2) ? (add2_q - m2) : add2_q;

  // stage 4: add or subtract modulo m
  assign m3  = tmrh_pkg::modulus(sel3_q);
  assign sum = {1'b0, r_q} + {1'b0, add3_q};
  assign dif = {1'b0, add3_q} + {1'b0, m3} - {1'b0, r_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v1_q    <= req_i.valid;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      valid_o <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= {31'b0, req_i.a} * {31'b0, req_i.b};
    add1_q <= req_i.add;
    sub1_q <= req_i.sub;
    sel1_q <= req_i.sel;
    x_q    <= x_d;
    add2_q <= add1_q;
    sub2_q <= sub1_q;
    sel2_q <= sel1_q;
    r_q    <= r_d;
    add3_q <= add_d;
    sub3_q <= sub2_q;
    sel3_q <= sel2_q;
    if (sub3_q) begin
      result_o <= (add3_q >= r_q) ? (add3_q - r_q) : dif[30:0];
    end else begin
      result_o <= (sum >= {1'b0, m3}) ? 31'(sum - {1'b0, m3}) : sum[30:0];
    end
  end

endmodule

// File: design/triple_mod_rolling_hash_table.sv
// ----------------------------------------------------------------------------
// triple_mod_rolling_hash_table
// Polynomial rolling hash over three fixed primes with prefix/power tables.
// ----------------------------------------------------------------------------
// Usage:
//   Present action_i and its operands with start high while busy is low; the
//   word is taken at that clock edge and busy rises on the next cycle.
//   Actions: clear, load one element, substring query, combine two hashes.
//   The result word (hash_m0_o..hash_m2_o, status_o) shows for exactly one
//   cycle with done_o high; the receiver cannot stall it, so capture it then.
//   busy is already low in the done_o cycle, so the next start may follow.
// Sequencing: a clear or any range error goes straight to ST_FIN, which raises
//   done_o. A load runs six multiply-mod jobs, a query or combine three, each
//   issued in ST_ISSUE and awaited in ST_WAIT through the four stages of the
//   one shared unit; the next job is issued only after the last one returns.
// base_multiplier_i is written when base_we_i is high; the user must write it
//   only while idle, as the block itself does not enforce it.
// Reset empties the table (loaded count zero, base 1665525); no clearing
// pass is needed since entry zero is supplied as a constant.
module triple_mod_rolling_hash_table #(
  parameter int unsigned MAX_LEN = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         action_i,
  input  logic [tmrh_pkg::RES_W-1:0]         element_value_i,
  input  logic [tmrh_pkg::POS_W-1:0]         offset_i,
  input  logic [tmrh_pkg::POS_W-1:0]         span_length_i,
  input  logic [tmrh_pkg::RES_W-1:0]         left_h0_i,
  input  logic [tmrh_pkg::RES_W-1:0]         left_h1_i,
  input  logic [tmrh_pkg::RES_W-1:0]         left_h2_i,
  input  logic [tmrh_pkg::RES_W-1:0]         right_h0_i,
  input  logic [tmrh_pkg::RES_W-1:0]         right_h1_i,
  input  logic [tmrh_pkg::RES_W-1:0]         right_h2_i,
  input  logic                               base_we_i,
  input  logic [tmrh_pkg::RES_W-1:0]         base_multiplier_i,
  output logic                               done_o,
  output logic [tmrh_pkg::RES_W-1:0]         hash_m0_o,
  output logic [tmrh_pkg::RES_W-1:0]         hash_m1_o,
  output logic [tmrh_pkg::RES_W-1:0]         hash_m2_o,
  output logic                               status_o
);

`include "triple_mod_rolling_hash_table_assert.svh"

  localparam int unsigned DEPTH = MAX_LEN + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = ((AW > tmrh_pkg::POS_W) ? AW : tmrh_pkg::POS_W) + 1;
  localparam int unsigned RW    = tmrh_pkg::RES_W;
  localparam int unsigned WW    = RW * tmrh_pkg::NUM_MOD;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_ISSUE,
    ST_WAIT,
    ST_FIN
  } state_e;

  state_e               state_q;
  tmrh_pkg::action_e    act_q;
  logic [AW-1:0]        count_q;
  logic [RW-1:0]        base_q;
  logic [RW-1:0]        elem_q;
  logic [AW-1:0]        sum_q;
  logic                 sum_zero_q, pre_zero_q, pw_zero_q, err_q;
  logic [1:0]           k_q;
  logic                 j_q;
  logic [RW-1:0]        left_q  [3];
  logic [RW-1:0]        right_q [3];
  logic [RW-1:0]        pre_a_q [3];
  logic [RW-1:0]        pre_b_q [3];
  logic [RW-1:0]        pw_q    [3];
  logic [RW-1:0]        pwn_q   [3];
  logic [RW-1:0]        res_q   [3];

  tmrh_pkg::action_e    act_in;
  logic [SW-1:0]        off_ext, len_ext, sum_ext, cnt_ext;
  logic                 accept, err_in, last_op;
  logic [AW-1:0]        pre_raddr, pw_raddr, waddr;
  logic [WW-1:0]        pre_rdata, pw_rdata, pre_wdata, pw_wdata;
  logic                 ram_we;
  tmrh_pkg::mm_req_t    req;
  logic                 rsp_valid;
  logic [RW-1:0]        rsp;

  assign act_in  = tmrh_pkg::action_e'(action_i);
  assign accept  = start && !busy;
  assign busy    = (state_q != ST_IDLE);
  assign off_ext = SW'(offset_i);
  assign len_ext = SW'(span_length_i);
  assign sum_ext = off_ext + len_ext;
  assign cnt_ext = SW'(count_q);

  // range checks on the incoming word
  always_comb begin
    unique case (act_in)
      tmrh_pkg::ACT_LOAD:    err_in = (cnt_ext >= SW'(MAX_LEN));
      tmrh_pkg::ACT_QUERY:   err_in = (sum_ext > cnt_ext);
      tmrh_pkg::ACT_COMBINE: err_in = (len_ext > cnt_ext);
      default:               err_in = 1'b0;
    endcase
  end

  // Table reads: first access at the accept edge, second prefix read in RD1
  assign pre_raddr = (state_q == ST_IDLE) ?
                     ((act_in == tmrh_pkg::ACT_LOAD) ? count_q : off_ext[AW-1:0]) : sum_q;
  assign pw_raddr  = (act_in == tmrh_pkg::ACT_LOAD) ? count_q : len_ext[AW-1:0];

  // Append new prefix and power words behind the last loaded entry
  assign ram_we    = (state_q == ST_FIN) && (act_q == tmrh_pkg::ACT_LOAD) && !err_q;
  assign waddr     = count_q + AW'(1);
  assign pre_wdata = {res_q[2], res_q[1], res_q[0]};
  assign pw_wdata  = {pwn_q[2], pwn_q[1], pwn_q[0]};

  tmrh_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_prefix_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (pre_wdata),
    .raddr_i (pre_raddr),
    .rdata_o (pre_rdata)
  );

  tmrh_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_power_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (pw_wdata),
    .raddr_i (pw_raddr),
    .rdata_o (pw_rdata)
  );

  // Build one multiply-mod job per modulus; a load runs two, power then prefix
  always_comb begin
    req       = '0;
    req.valid = (state_q == ST_ISSUE);
    req.sel   = k_q;
    req.sub   = (act_q == tmrh_pkg::ACT_QUERY);
    case (act_q)
      tmrh_pkg::ACT_LOAD: begin
        req.a   = j_q ? pre_a_q[k_q] : pw_q[k_q];
        req.b   = base_q;
        req.add = j_q ? elem_q : '0;
      end
      tmrh_pkg::ACT_QUERY: begin
        req.a   = pre_a_q[k_q];
        req.b   = pw_q[k_q];
        req.add = pre_b_q[k_q];
      end
      default: begin
        req.a   = left_q[k_q];
        req.b   = pw_q[k_q];
        req.add = right_q[k_q];
      end
    endcase
  end

  assign last_op = (k_q == 2'd2) && ((act_q != tmrh_pkg::ACT_LOAD) || j_q);

  tmrh_mulmod u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .valid_o  (rsp_valid),
    .result_o (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      act_q      <= tmrh_pkg::ACT_CLEAR;
      count_q    <= '0;
      base_q     <= 31'd1665525;
      elem_q     <= '0;
      sum_q      <= '0;
      sum_zero_q <= 1'b0;
      pre_zero_q <= 1'b0;
      pw_zero_q  <= 1'b0;
      err_q      <= 1'b0;
      k_q        <= '0;
      j_q        <= 1'b0;
      done_o     <= 1'b0;
      hash_m0_o  <= '0;
      hash_m1_o  <= '0;
      hash_m2_o  <= '0;
      status_o   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        left_q[i]  <= '0;
        right_q[i] <= '0;
        pre_a_q[i] <= '0;
        pre_b_q[i] <= '0;
        pw_q[i]    <= '0;
        pwn_q[i]   <= '0;
        res_q[i]   <= '0;
      end
    end else begin
      done_o <= 1'b0;
      if (base_we_i) begin
        base_q <= base_multiplier_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            act_q      <= act_in;
            elem_q     <= element_value_i;
            sum_q      <= sum_ext[AW-1:0];
            sum_zero_q <= (sum_ext == '0);
            pre_zero_q <= (act_in == tmrh_pkg::ACT_LOAD) ? (count_q == '0) : (offset_i == '0);
            pw_zero_q  <= (act_in == tmrh_pkg::ACT_LOAD) ? (count_q == '0)
                                                         : (span_length_i == '0);
            err_q      <= err_in;
            left_q[0]  <= left_h0_i;
            left_q[1]  <= left_h1_i;
            left_q[2]  <= left_h2_i;
            right_q[0] <= right_h0_i;
            right_q[1] <= right_h1_i;
            right_q[2] <= right_h2_i;
            k_q        <= '0;
            j_q        <= 1'b0;
            if (act_in == tmrh_pkg::ACT_CLEAR || err_in) begin
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_RD1;
            end
          end
        end
        ST_RD1: begin
          // entry zero is never stored: prefix 0, power 1
          for (int i = 0; i < 3; i++) begin
            pre_a_q[i] <= pre_zero_q ? '0 : pre_rdata[i*RW +: RW];
            pw_q[i]    <= pw_zero_q ? RW'(1) : pw_rdata[i*RW +: RW];
          end
          state_q <= (act_q == tmrh_pkg::ACT_QUERY) ? ST_RD2 : ST_ISSUE;
        end
        ST_RD2: begin
          for (int i = 0; i < 3; i++) begin
            pre_b_q[i] <= sum_zero_q ? '0 : pre_rdata[i*RW +: RW];
          end
          state_q <= ST_ISSUE;
        end
        ST_ISSUE: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (rsp_valid) begin
            if (act_q == tmrh_pkg::ACT_LOAD && !j_q) begin
              pwn_q[k_q] <= rsp;
            end else begin
              res_q[k_q] <= rsp;
            end
            if (last_op) begin
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_ISSUE;
              if (act_q == tmrh_pkg::ACT_LOAD && !j_q) begin
                j_q <= 1'b1;
              end else begin
                j_q <= 1'b0;
                k_q <= k_q + 2'd1;
              end
            end
          end
        end
        ST_FIN: begin
          done_o   <= 1'b1;
          status_o <= err_q;
          if (err_q || act_q == tmrh_pkg::ACT_CLEAR) begin
            hash_m0_o <= '0;
            hash_m1_o <= '0;
            hash_m2_o <= '0;
          end else begin
            hash_m0_o <= res_q[0];
            hash_m1_o <= res_q[1];
            hash_m2_o <= res_q[2];
          end
          if (act_q == tmrh_pkg::ACT_CLEAR) begin
            count_q <= '0;
          end else if (ram_we) begin
            count_q <= waddr;
          end
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `TMRH_ASSERT_IMP(a_done_idle, done_o, !busy)
  `TMRH_ASSERT_NXT(a_accept_busy, accept, busy)
  `TMRH_ASSERT_IMP(a_count_cap, 1'b1, SW'(count_q) <= SW'(MAX_LEN))
  `TMRH_ASSERT_IMP(a_err_zero, done_o && status_o,
                   hash_m0_o == '0 && hash_m1_o == '0 && hash_m2_o == '0)
  `TMRH_ASSERT_IMP(a_rsp_wait, rsp_valid, state_q == ST_WAIT)

endmodule
